// File: design/fhpd_pkg.sv
// Shared types and constants for the frame hit peak detector.
`default_nettype none

package fhpd_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 13;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DETECT_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT     = 2'd2;

  // Field widths.
  localparam int unsigned LEVEL_BITS  = 8;
  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned REPORT_BITS = 32;

  // Register values after reset.
  localparam logic [LEVEL_BITS-1:0] RESET_THRESHOLD = 8'd200;
  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  // One result item, as delivered at the end of a frame.
  typedef struct packed {
    logic                   hit_found;
    logic [COORD_BITS-1:0]  hit_x;
    logic [COORD_BITS-1:0]  hit_y;
    logic [LEVEL_BITS-1:0]  hit_level;
    logic [REPORT_BITS-1:0] frame_number;
    logic [REPORT_BITS-1:0] hit_index;
  } result_t;

endpackage

`default_nettype wire

// File: design/fhpd_cfg.sv
// Configuration registers; frame sizes are stored as clamped last positions.
`default_nettype none

module fhpd_cfg #(
  parameter int unsigned MAX_SIDE  = 4096,
  parameter int unsigned SIDE_BITS = 12
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [fhpd_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  wire logic [fhpd_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  output logic      [fhpd_pkg::LEVEL_BITS-1:0]        threshold_o,
  output logic      [SIDE_BITS-1:0]                   last_col_o,
  output logic      [SIDE_BITS-1:0]                   last_row_o
);

  // Compare width that holds both a written size and MAX_SIDE itself.
  localparam int unsigned CmpBits = (SIDE_BITS + 1 > fhpd_pkg::CFG_DATA_BITS) ?
                                    SIDE_BITS + 1 : fhpd_pkg::CFG_DATA_BITS;
  localparam int unsigned ResetLastCol =
    ((fhpd_pkg::RESET_WIDTH > MAX_SIDE) ? MAX_SIDE : fhpd_pkg::RESET_WIDTH) - 1;
  localparam int unsigned ResetLastRow =
    ((fhpd_pkg::RESET_HEIGHT > MAX_SIDE) ? MAX_SIDE : fhpd_pkg::RESET_HEIGHT) - 1;

  logic [fhpd_pkg::LEVEL_BITS-1:0] threshold_q, threshold_d;
  logic [SIDE_BITS-1:0]            last_col_q, last_col_d;
  logic [SIDE_BITS-1:0]            last_row_q, last_row_d;
  logic [CmpBits-1:0]              size_ext;
  logic [CmpBits-1:0]              size_last;

  // A size of zero counts as one, anything above MAX_SIDE as MAX_SIDE.
  always_comb begin
    size_ext = CmpBits'(cfg_data_i);
    if (size_ext == '0) begin
      size_last = '0;
    end else if (size_ext > CmpBits'(MAX_SIDE)) begin
      size_last = CmpBits'(MAX_SIDE - 1);
    end else begin
      size_last = size_ext - CmpBits'(1);
    end
  end

  // Register write decode; unknown indexes are ignored.
  always_comb begin
    threshold_d = threshold_q;
    last_col_d  = last_col_q;
    last_row_d  = last_row_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fhpd_pkg::CFG_DETECT_THRESHOLD: threshold_d = cfg_data_i[fhpd_pkg::LEVEL_BITS-1:0];
        fhpd_pkg::CFG_FRAME_WIDTH:      last_col_d  = SIDE_BITS'(size_last);
        fhpd_pkg::CFG_FRAME_HEIGHT:     last_row_d  = SIDE_BITS'(size_last);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= fhpd_pkg::RESET_THRESHOLD;
      last_col_q  <= SIDE_BITS'(ResetLastCol);
      last_row_q  <= SIDE_BITS'(ResetLastRow);
    end else begin
      threshold_q <= threshold_d;
      last_col_q  <= last_col_d;
      last_row_q  <= last_row_d;
    end
  end

  assign threshold_o = threshold_q;
  assign last_col_o  = last_col_q;
  assign last_row_o  = last_row_q;

endmodule

`default_nettype wire

// File: design/fhpd_track.sv
// Raster position, per-frame peak tracker and the frame and hit counters.
`default_nettype none

module fhpd_track #(
  parameter int unsigned SIDE_BITS  = 12,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire logic [fhpd_pkg::LEVEL_BITS-1:0]   level_i,
  input  wire logic [fhpd_pkg::LEVEL_BITS-1:0]   threshold_i,
  input  wire logic [SIDE_BITS-1:0]              last_col_i,
  input  wire logic [SIDE_BITS-1:0]              last_row_i,
  output logic                                   frame_end_o,
  output fhpd_pkg::result_t                      result_o
);

  logic [SIDE_BITS-1:0]            col_q, col_d;
  logic [SIDE_BITS-1:0]            row_q, row_d;
  logic [fhpd_pkg::LEVEL_BITS-1:0] best_level_q, best_level_d;
  logic [SIDE_BITS-1:0]            best_col_q, best_col_d;
  logic [SIDE_BITS-1:0]            best_row_q, best_row_d;
  logic                            seen_q, seen_d;
  logic [COUNT_BITS-1:0]           hits_q, hits_d;
  logic [COUNT_BITS-1:0]           frames_q, frames_d;

  logic                            take;
  logic                            row_end;
  logic                            frame_end;
  logic [fhpd_pkg::LEVEL_BITS-1:0] upd_level;
  logic [SIDE_BITS-1:0]            upd_col;
  logic [SIDE_BITS-1:0]            upd_row;
  logic                            upd_seen;

  // Peak update: ties go to the later pixel.
  assign take      = (level_i >= threshold_i) && (level_i >= best_level_q);
  assign upd_level = take ? level_i : best_level_q;
  assign upd_col   = take ? col_q   : best_col_q;
  assign upd_row   = take ? row_q   : best_row_q;
  assign upd_seen  = seen_q | take;

  // Row and frame ends; a counter past a shrunk size ends at once.
  assign row_end   = (col_q >= last_col_i);
  assign frame_end = row_end && (row_q >= last_row_i);

  // Result of the pixel under consideration, used only at a frame end.
  always_comb begin
    result_o.hit_found    = upd_seen;
    result_o.hit_x        = upd_seen ? fhpd_pkg::COORD_BITS'(upd_col) : '0;
    result_o.hit_y        = upd_seen ? fhpd_pkg::COORD_BITS'(upd_row) : '0;
    result_o.hit_level    = upd_seen ? upd_level : '0;
    result_o.frame_number = fhpd_pkg::REPORT_BITS'(frames_q);
    result_o.hit_index    = upd_seen ? fhpd_pkg::REPORT_BITS'(hits_q) : '0;
  end

  // Next state for one accepted pixel.
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    best_level_d = best_level_q;
    best_col_d   = best_col_q;
    best_row_d   = best_row_q;
    seen_d       = seen_q;
    hits_d       = hits_q;
    frames_d     = frames_q;
    if (step_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + SIDE_BITS'(1);
      end else begin
        col_d = col_q + SIDE_BITS'(1);
      end
      if (frame_end) begin
        best_level_d = '0;
        best_col_d   = '0;
        best_row_d   = '0;
        seen_d       = 1'b0;
        frames_d     = frames_q + COUNT_BITS'(1);
        if (upd_seen) begin
          hits_d = hits_q + COUNT_BITS'(1);
        end
      end else begin
        best_level_d = upd_level;
        best_col_d   = upd_col;
        best_row_d   = upd_row;
        seen_d       = upd_seen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      best_level_q <= '0;
      best_col_q   <= '0;
      best_row_q   <= '0;
      seen_q       <= 1'b0;
      hits_q       <= '0;
      frames_q     <= '0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      best_level_q <= best_level_d;
      best_col_q   <= best_col_d;
      best_row_q   <= best_row_d;
      seen_q       <= seen_d;
      hits_q       <= hits_d;
      frames_q     <= frames_d;
    end
  end

  assign frame_end_o = frame_end;

endmodule

`default_nettype wire

// File: design/frame_hit_peak_detector.sv
// Top level of the frame hit peak detector: input register, tracker and result register.
//
// Gray pixels arrive in raster order, one request per cycle, and pass through an
// input register into the peak tracker; the tracker updates its state in the same
// cycle. A result request is loaded into the output register at the edge at which the
// last pixel of a frame leaves the input register, and can be taken
// from the next edge on.
// Throughput is one pixel per clock; the only stall is a frame's last pixel meeting
// an output register whose previous result has not yet been taken. Configuration
// writes take effect on the next clock and should be made while no pixel is in flight.
`default_nettype none

module frame_hit_peak_detector #(
  parameter int unsigned MAX_SIDE   = 4096,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [fhpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  wire logic [fhpd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  // Pixel channel
  input  wire logic                                 pixel_valid_i,
  output logic                                      pixel_ready_o,
  input  wire logic [fhpd_pkg::LEVEL_BITS-1:0]      pixel_level_i,
  // Result channel
  output logic                                      result_valid_o,
  input  wire logic                                 result_ready_i,
  output logic                                      hit_found_o,
  output logic      [fhpd_pkg::COORD_BITS-1:0]      hit_x_o,
  output logic      [fhpd_pkg::COORD_BITS-1:0]      hit_y_o,
  output logic      [fhpd_pkg::LEVEL_BITS-1:0]      hit_level_o,
  output logic      [fhpd_pkg::REPORT_BITS-1:0]     frame_number_o,
  output logic      [fhpd_pkg::REPORT_BITS-1:0]     hit_index_o
);

  localparam int unsigned SideBits = $clog2(MAX_SIDE);

  logic [fhpd_pkg::LEVEL_BITS-1:0] threshold;
  logic [SideBits-1:0]             last_col;
  logic [SideBits-1:0]             last_row;
  logic                            frame_end;
  fhpd_pkg::result_t               track_result;

  logic                            in_valid_q, in_valid_d;
  logic [fhpd_pkg::LEVEL_BITS-1:0] in_level_q;
  logic                            res_valid_q, res_valid_d;
  fhpd_pkg::result_t               res_q;
  logic                            out_free;
  logic                            step;
  logic                            in_take;

  fhpd_cfg #(
    .MAX_SIDE  (MAX_SIDE),
    .SIDE_BITS (SideBits)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .threshold_o (threshold),
    .last_col_o  (last_col),
    .last_row_o  (last_row)
  );

  fhpd_track #(
    .SIDE_BITS  (SideBits),
    .COUNT_BITS (COUNT_BITS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .level_i     (in_level_q),
    .threshold_i (threshold),
    .last_col_i  (last_col),
    .last_row_i  (last_row),
    .frame_end_o (frame_end),
    .result_o    (track_result)
  );

  // The held pixel moves on unless it ends a frame and the result slot is busy.
  assign out_free      = !res_valid_q || result_ready_i;
  assign step          = in_valid_q && (!frame_end || out_free);
  assign pixel_ready_o = !in_valid_q || step;
  assign in_take       = pixel_valid_i && pixel_ready_o;

  // Input register.
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  // Result register.
  always_comb begin
    res_valid_d = res_valid_q;
    if (step && frame_end) begin
      res_valid_d = 1'b1;
    end else if (result_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_level_q <= pixel_level_i;
    end
    if (step && frame_end) begin
      res_q <= track_result;
    end
  end

  assign result_valid_o = res_valid_q;
  assign hit_found_o    = res_q.hit_found;
  assign hit_x_o        = res_q.hit_x;
  assign hit_y_o        = res_q.hit_y;
  assign hit_level_o    = res_q.hit_level;
  assign frame_number_o = res_q.frame_number;
  assign hit_index_o    = res_q.hit_index;

endmodule

`default_nettype wire
